// File: rtl/core/glcd_pkg.sv
// Shared types and constants for the serial graphic LCD command encoder.
// Request modes, frame byte positions, the queued job record and the digit step.
// No dependencies.
package glcd_pkg;

    typedef enum logic [2:0] {
        MODE_CMD    = 3'd0,
        MODE_DATA   = 3'd1,
        MODE_CURSOR = 3'd2,
        MODE_PIXEL  = 3'd3,
        MODE_NUMBER = 3'd4
    } mode_t;

    localparam logic [1:0] BYTE_SYNC = 2'd0;
    localparam logic [1:0] BYTE_HIGH = 2'd1;
    localparam logic [1:0] BYTE_LOW  = 2'd2;

    localparam logic [7:0]  SYNC_COM   = 8'hF8;
    localparam logic [7:0]  SYNC_DAT   = 8'hFA;
    localparam logic [7:0]  NIB_MASK   = 8'hF0;
    localparam logic [7:0]  ADDR_FLAG  = 8'h80;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;
    localparam logic [13:0] NUM_MAX    = 14'd9999;

    localparam int MAX_FRAMES = 5;

    localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

    typedef struct packed {
        logic [2:0]                  count;
        logic [MAX_FRAMES-1:0]       is_data;
        logic [MAX_FRAMES-1:0][7:0]  data;
    } job_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [13:0] rest;
    } digit_t;

    function automatic digit_t digit_step(input logic [13:0] v, input logic [13:0] place);
        digit_t      res;
        logic [13:0] thr;
        res.digit = 4'd0;
        res.rest  = v;
        for (int k = 1; k <= 9; k++) begin
            thr = 14'(k) * place;
            if (v >= thr) begin
                res.digit = 4'(k);
                res.rest  = v - thr;
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/glcd_front.sv
// Request front end: accepts requests, classifies them and builds frame jobs.
// Number digits: thousands on acceptance, hundreds in ST_HUND, tens and units in ST_TENS. Depends on glcd_pkg.
module glcd_front import glcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [7:0]  byte_value,
    input  logic [6:0]  pos_x,
    input  logic [5:0]  pos_y,
    input  logic [13:0] number,
    output logic        push,
    output job_t        push_job,
    input  logic        q_full
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HUND = 3'b010,
        ST_TENS = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [7:0]  cursor_reg, cursor_next;
    logic [3:0]  thou_reg, thou_next;
    logic [3:0]  hund_reg, hund_next;
    logic [13:0] rem_reg, rem_next;

    logic        accept;
    logic [7:0]  text_addr;
    logic [13:0] sat_num;
    digit_t      thou_d, hund_d, tens_d;
    logic [3:0]  pix_bit;
    logic [7:0]  pix_mask;

    assign in_ready  = (state_reg == ST_IDLE) && !q_full;
    assign accept    = in_valid && in_ready;
    assign text_addr = ROW_BASE[pos_y[1:0]] + {5'd0, pos_x[2:0]};
    assign sat_num   = (number > NUM_MAX) ? NUM_MAX : number;
    assign thou_d    = digit_step(sat_num, 14'd1000);
    assign hund_d    = digit_step(rem_reg, 14'd100);
    assign tens_d    = digit_step(rem_reg, 14'd10);
    assign pix_bit   = pos_x[3:0];
    assign pix_mask  = ADDR_FLAG >> pix_bit[2:0];

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        thou_next   = thou_reg;
        hund_next   = hund_reg;
        rem_next    = rem_reg;
        push        = 1'b0;
        push_job    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_CMD, MODE_DATA:
                        begin
                            push                = 1'b1;
                            push_job.count      = 3'd1;
                            push_job.is_data[0] = (mode == MODE_DATA);
                            push_job.data[0]    = byte_value;
                        end
                        MODE_CURSOR:
                        begin
                            push             = 1'b1;
                            push_job.count   = 3'd1;
                            push_job.data[0] = text_addr;
                        end
                        MODE_PIXEL:
                        begin
                            push             = 1'b1;
                            push_job.count   = 3'd4;
                            push_job.is_data = 5'b01100;
                            push_job.data[0] = ADDR_FLAG | {3'd0, pos_y[4:0]};
                            push_job.data[1] = ADDR_FLAG | {4'd0, pos_y[5], pos_x[6:4]};
                            push_job.data[2] = pix_bit[3] ? 8'd0 : pix_mask;
                            push_job.data[3] = pix_bit[3] ? pix_mask : 8'd0;
                        end
                        MODE_NUMBER:
                        begin
                            cursor_next = text_addr;
                            thou_next   = thou_d.digit;
                            rem_next    = thou_d.rest;
                            state_next  = ST_HUND;
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            ST_HUND:
            begin
                hund_next  = hund_d.digit;
                rem_next   = hund_d.rest;
                state_next = ST_TENS;
            end
            ST_TENS:
            begin
                push             = !q_full;
                push_job.count   = 3'd5;
                push_job.is_data = 5'b11110;
                push_job.data[0] = cursor_reg;
                push_job.data[1] = ASCII_ZERO | {4'd0, thou_reg};
                push_job.data[2] = ASCII_ZERO | {4'd0, hund_reg};
                push_job.data[3] = ASCII_ZERO | {4'd0, tens_d.digit};
                push_job.data[4] = ASCII_ZERO | {4'd0, tens_d.rest[3:0]};
                if (!q_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        thou_reg   <= thou_next;
        hund_reg   <= hund_next;
        rem_reg    <= rem_next;
    end

endmodule

// File: rtl/core/glcd_queue.sv
// Short job queue between the request front end and the byte serializer.
// Depends on glcd_pkg for the job record.
module glcd_queue import glcd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/glcd_back.sv
// Byte serializer: walks the frames of the head job, three link bytes per frame.
// Drives the registered output stream. Depends on glcd_pkg.
module glcd_back import glcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] link_byte,
    output logic       frame_end,
    output logic       last
);

    logic [2:0] frame_reg, frame_next;
    logic [1:0] pos_reg, pos_next;
    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       fend_reg, fend_next;
    logic       last_reg, last_next;
    logic       advance, emit;
    logic [7:0] cur_data;
    logic       cur_is_data;
    logic       last_frame;

    assign advance     = !valid_reg || out_ready;
    assign emit        = advance && !empty;
    assign cur_data    = head.data[frame_reg];
    assign cur_is_data = head.is_data[frame_reg];
    assign last_frame  = (frame_reg == 3'(head.count - 3'd1));

    always_comb
    begin
        frame_next = frame_reg;
        pos_next   = pos_reg;
        fend_next  = 1'b0;
        last_next  = 1'b0;
        pop        = 1'b0;
        case (pos_reg)
            BYTE_SYNC: byte_next = cur_is_data ? SYNC_DAT : SYNC_COM;
            BYTE_HIGH: byte_next = cur_data & NIB_MASK;
            default:   byte_next = {cur_data[3:0], 4'd0};
        endcase
        if (pos_reg == BYTE_LOW)
        begin
            fend_next = 1'b1;
            last_next = last_frame;
        end
        if (emit)
        begin
            if (pos_reg == BYTE_LOW)
            begin
                pos_next = BYTE_SYNC;
                if (last_frame)
                begin
                    frame_next = '0;
                    pop        = 1'b1;
                end
                else
                begin
                    frame_next = frame_reg + 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            pos_reg   <= BYTE_SYNC;
            valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg <= frame_next;
            pos_reg   <= pos_next;
            if (advance)
            begin
                valid_reg <= !empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= byte_next;
            fend_reg <= fend_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign link_byte = byte_reg;
    assign frame_end = fend_reg;
    assign last      = last_reg;

endmodule

// File: rtl/core/graphic_lcd_serial_command_encoder.sv
// Serial graphic LCD command encoder, top level.
// Instantiates glcd_front, glcd_queue and glcd_back; depends on glcd_pkg.
//
// Usage:
//   s_axis carries one display request: tuser is the mode, tdata the operands.
//   m_axis carries the link bytes, one per transaction, in serial shift order;
//   tuser marks the third byte of a chip-select frame, tlast the final byte
//   of a request.
// Path: the bytes of a request pass through the job queue and the output register;
//   a number request first passes through the hundreds and tens digit states.
// Throughput: the serializer emits one byte per cycle while the output is not stalled
//   and a job is queued; a request is 3 bytes (command, data, cursor), 12 (pixel)
//   or 15 (number). The front end takes a request per cycle while the job queue has
//   room and it is not busy with a number. Modes 5 to 7 are accepted and produce nothing.
// Reset: the queue empties, the serializer restarts at the first frame and no
//   output is valid.
// Stall: while m_axis_tready is low the output byte holds; the queue fills and
//   then s_axis_tready drops.
module graphic_lcd_serial_command_encoder import glcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // byte_value[7:0], pos_x[14:8], pos_y[20:15], number[34:21]
    input  logic [2:0]  s_axis_tuser,  // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // link_byte[7:0]
    output logic        m_axis_tuser,  // frame_end
    output logic        m_axis_tlast
);

    logic push, q_full, pop, q_empty;
    job_t push_job, head_job;

    glcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .mode       (s_axis_tuser),
        .byte_value (s_axis_tdata[7:0]),
        .pos_x      (s_axis_tdata[14:8]),
        .pos_y      (s_axis_tdata[20:15]),
        .number     (s_axis_tdata[34:21]),
        .push       (push),
        .push_job   (push_job),
        .q_full     (q_full)
    );

    glcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head_job),
        .empty    (q_empty)
    );

    glcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_job),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .link_byte (m_axis_tdata),
        .frame_end (m_axis_tuser),
        .last      (m_axis_tlast)
    );

endmodule

// File: sim/tb_graphic_lcd_serial_command_encoder.sv
// Testbench for graphic_lcd_serial_command_encoder: drives display requests on s_axis, predicts the
// link byte stream and checks every m_axis transaction against it, under varying back-pressure.
// Depends on glcd_pkg and the encoder RTL.
module tb_graphic_lcd_serial_command_encoder import glcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STALL_LIMIT   = 4000;
    localparam int         MAX_REPORTS   = 10;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       frame_end;
        logic       last;
    } link_byte_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    link_byte_t  link_bytes_due[$];
    link_byte_t  due;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          bytes_checked  = 0;
    int          idle_cycles    = 0;
    int          requests_by_mode[8];
    int          saturated_numbers = 0;

    graphic_lcd_serial_command_encoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] text_cursor_cmd(input logic [6:0] x, input logic [5:0] y);
        logic [7:0] base;
        case (y[1:0])
            2'd0:    base = 8'h80;
            2'd1:    base = 8'h90;
            2'd2:    base = 8'h88;
            default: base = 8'h98;
        endcase
        return base + {5'd0, x[2:0]};
    endfunction

    task automatic encode_request(input logic [2:0] mode, input logic [7:0] bv,
                                  input logic [6:0] x, input logic [5:0] y,
                                  input logic [13:0] num);
        logic [7:0]  frame_val [5];
        bit          frame_dat [5];
        int          nframes;
        logic [13:0] shown;
        logic [5:0]  row;
        logic [3:0]  col;
        logic [3:0]  pix;
        link_byte_t  lb;
        nframes = 0;
        case (mode)
            MODE_CMD, MODE_DATA:
            begin
                frame_val[0] = bv;
                frame_dat[0] = (mode == MODE_DATA);
                nframes = 1;
            end
            MODE_CURSOR:
            begin
                frame_val[0] = text_cursor_cmd(x, y);
                frame_dat[0] = 1'b0;
                nframes = 1;
            end
            MODE_PIXEL:
            begin
                row = y[5] ? y - 6'd32 : y;
                col = {1'b0, x[6:4]} + (y[5] ? 4'd8 : 4'd0);
                pix = x[3:0];
                frame_val[0] = ADDR_FLAG | {2'd0, row};
                frame_val[1] = ADDR_FLAG | {4'd0, col};
                frame_val[2] = pix[3] ? 8'h00 : (8'h80 >> pix[2:0]);
                frame_val[3] = pix[3] ? (8'h80 >> pix[2:0]) : 8'h00;
                frame_dat[0] = 1'b0;
                frame_dat[1] = 1'b0;
                frame_dat[2] = 1'b1;
                frame_dat[3] = 1'b1;
                nframes = 4;
            end
            MODE_NUMBER:
            begin
                shown = (num > NUM_MAX) ? NUM_MAX : num;
                frame_val[0] = text_cursor_cmd(x, y);
                frame_val[1] = ASCII_ZERO + 8'(shown / 1000);
                frame_val[2] = ASCII_ZERO + 8'((shown % 1000) / 100);
                frame_val[3] = ASCII_ZERO + 8'((shown % 100) / 10);
                frame_val[4] = ASCII_ZERO + 8'(shown % 10);
                frame_dat[0] = 1'b0;
                for (int k = 1; k < 5; k++)
                begin
                    frame_dat[k] = 1'b1;
                end
                nframes = 5;
            end
            default:
            begin
                nframes = 0;
            end
        endcase
        for (int k = 0; k < nframes; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                case (i)
                    0:       lb.link_byte = frame_dat[k] ? SYNC_DAT : SYNC_COM;
                    1:       lb.link_byte = frame_val[k] & NIB_MASK;
                    default: lb.link_byte = {frame_val[k][3:0], 4'h0};
                endcase
                lb.frame_end = (i == 2);
                lb.last      = (i == 2) && (k == nframes - 1);
                link_bytes_due.push_back(lb);
            end
        end
    endtask

    task automatic send_request(input logic [2:0] mode, input logic [7:0] bv,
                                input logic [6:0] x, input logic [5:0] y,
                                input logic [13:0] num);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {5'd0, num, y, x, bv};
        do
            @(posedge clk);
        while (!s_axis_tready);
        encode_request(mode, bv, x, y, num);
        requests_by_mode[mode]++;
        if (mode == MODE_NUMBER && num > NUM_MAX)
            saturated_numbers++;
    endtask

    task automatic test_raw_bytes();
        send_request(MODE_CMD,  8'h00, 7'($urandom), 6'($urandom), 14'($urandom));
        send_request(MODE_CMD,  8'hFF, 7'($urandom), 6'($urandom), 14'($urandom));
        send_request(MODE_DATA, 8'h00, 7'($urandom), 6'($urandom), 14'($urandom));
        send_request(MODE_DATA, 8'hFF, 7'($urandom), 6'($urandom), 14'($urandom));
        send_request(MODE_CMD,  8'hA5, 7'd0, 6'd0, 14'd0);
        send_request(MODE_DATA, 8'h5A, 7'd127, 6'd63, 14'd16383);
    endtask

    task automatic test_text_cursor();
        send_request(MODE_CURSOR, 8'($urandom), 7'd0,   6'd0,  14'($urandom));
        send_request(MODE_CURSOR, 8'($urandom), 7'd7,   6'd3,  14'($urandom));
        send_request(MODE_CURSOR, 8'($urandom), 7'd127, 6'd63, 14'($urandom));
        send_request(MODE_CURSOR, 8'($urandom), 7'd5,   6'd6,  14'($urandom));
    endtask

    task automatic test_pixel_plot();
        send_request(MODE_PIXEL, 8'($urandom), 7'd0,   6'd0,  14'($urandom));
        send_request(MODE_PIXEL, 8'($urandom), 7'd127, 6'd63, 14'($urandom));
        send_request(MODE_PIXEL, 8'($urandom), 7'd15,  6'd31, 14'($urandom));
        send_request(MODE_PIXEL, 8'($urandom), 7'd16,  6'd32, 14'($urandom));
        send_request(MODE_PIXEL, 8'($urandom), 7'd8,   6'd0,  14'($urandom));
        send_request(MODE_PIXEL, 8'($urandom), 7'd7,   6'd33, 14'($urandom));
    endtask

    task automatic test_number_display();
        send_request(MODE_NUMBER, 8'($urandom), 7'd0,   6'd0,  14'd0);
        send_request(MODE_NUMBER, 8'($urandom), 7'd7,   6'd3,  14'd9999);
        send_request(MODE_NUMBER, 8'($urandom), 7'd127, 6'd63, 14'd10000);
        send_request(MODE_NUMBER, 8'($urandom), 7'd3,   6'd1,  14'd16383);
        send_request(MODE_NUMBER, 8'($urandom), 7'd4,   6'd2,  14'd1234);
        send_request(MODE_NUMBER, 8'($urandom), 7'd90,  6'd45, 14'd9);
    endtask

    task automatic test_ignored_modes();
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
        begin
            send_request(3'(m), 8'($urandom), 7'($urandom), 6'($urandom), 14'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int          sent;
        logic [2:0]  mode;
        logic [13:0] num;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 4)
                mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
            else
                mode = 3'($urandom_range(MODE_NUMBER, MODE_CMD));
            if ($urandom_range(9) == 0)
                num = 14'($urandom_range(16383, 10000));
            else
                num = 14'($urandom_range(9999));
            send_request(mode, 8'($urandom), 7'($urandom), 6'($urandom), num);
            if (mode <= MODE_NUMBER)
                sent++;
        end
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bytes_checked++;
            if (link_bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected byte %h frame_end %b last %b", $realtime,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                due = link_bytes_due.pop_front();
                if (m_axis_tdata !== due.link_byte || m_axis_tuser !== due.frame_end ||
                    m_axis_tlast !== due.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: byte %0d expected %h/%b/%b got %h/%b/%b", $realtime,
                                 bytes_checked, due.link_byte, due.frame_end, due.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct  = 35;
        recv_stall_pct = 65;
        test_raw_bytes();
        test_text_cursor();
        test_pixel_plot();
        test_number_display();
        test_ignored_modes();
        test_random_traffic(95, 35, 65);
        test_random_traffic(95, 65, 35);
        test_random_traffic(95, 0, 0);
        s_axis_tvalid <= 1'b0;
        while (link_bytes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (link_bytes_due.size() != 0)
            mismatches++;
        $display("Requests: cmd %0d, data %0d, cursor %0d, pixel %0d, number %0d (%0d clipped)",
                 requests_by_mode[MODE_CMD], requests_by_mode[MODE_DATA],
                 requests_by_mode[MODE_CURSOR], requests_by_mode[MODE_PIXEL],
                 requests_by_mode[MODE_NUMBER], saturated_numbers);
        $display("Spare modes %0d; link bytes checked %0d; mismatches %0d",
                 requests_by_mode[5] + requests_by_mode[6] + requests_by_mode[7],
                 bytes_checked, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/glcd_pkg.sv
rtl/core/glcd_front.sv
rtl/core/glcd_queue.sv
rtl/core/glcd_back.sv
rtl/core/graphic_lcd_serial_command_encoder.sv
sim/tb_graphic_lcd_serial_command_encoder.sv
